// ----- rtl/core/tcc_pkg.sv -----
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared constants, codes and control-word types of the text console engine.
// ----------------------------------------------------------------------------
package tcc_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;
    localparam int RW      = 5;                 // row field width
    localparam int CW      = 7;                 // column field width
    localparam int AW      = $clog2(CELLS);     // screen store address width
    localparam int UW      = 4;                 // micro-PC width

    localparam logic [AW-1:0] ADDR_LAST      = AW'(CELLS - 1);
    localparam logic [AW-1:0] ADDR_COPY_LAST = AW'((ROWS - 1) * COLUMNS - 1);

    // operation codes carried in tuser
    localparam logic [1:0] MODE_PUT   = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [7:0]  ATTR_RESET = 8'h07;
    localparam logic [15:0] CELL_RESET = {ATTR_RESET, CH_SPACE};

    // micro-program entry points and loop heads
    localparam logic [UW-1:0] S_INIT      = 4'd0;
    localparam logic [UW-1:0] S_INIT_FILL = 4'd1;
    localparam logic [UW-1:0] S_CLR       = 4'd2;
    localparam logic [UW-1:0] S_CLR_FILL  = 4'd3;
    localparam logic [UW-1:0] S_READ      = 4'd4;
    localparam logic [UW-1:0] S_RESULT    = 4'd5;
    localparam logic [UW-1:0] S_PUT       = 4'd6;
    localparam logic [UW-1:0] S_COPY_RD   = 4'd7;
    localparam logic [UW-1:0] S_COPY_WR   = 4'd8;
    localparam logic [UW-1:0] S_FILL_LAST = 4'd9;

    typedef enum logic [1:0] {A_HOLD, A_ZERO, A_INC} t_addr_op;
    typedef enum logic [1:0] {WE_OFF, WE_ON, WE_PRINT} t_we;
    typedef enum logic [1:0] {W_RESET, W_BLANK, W_CHAR, W_COPY} t_wsel;
    typedef enum logic {WA_CNT, WA_CUR} t_asel;
    typedef enum logic {R_CELL, R_NEXT} t_rsel;
    typedef enum logic [1:0] {CUR_NONE, CUR_PUT, CUR_HOME} t_cur;
    typedef enum logic [1:0] {C_NEVER, C_SCROLL, C_COPY_MORE, C_FILL_MORE} t_cond;
    typedef enum logic [1:0] {E_NONE, E_QUIET, E_RESULT} t_end;

    typedef struct packed {
        t_addr_op        addr_op;
        t_we             we;
        t_wsel           wsel;
        t_asel           asel;
        logic            rd_en;
        t_rsel           rsel;
        t_cur            cur_op;
        t_cond           cond;
        logic [UW-1:0]   target;
        t_end            fin;
    } t_uword;

    typedef struct packed {
        t_uword          uw;
        logic            en;     // step executes this cycle
        logic            take;   // input word accepted this cycle
    } t_ctl;

    typedef struct packed {
        logic            need_scroll;
        logic            copy_end;
        logic            fill_end;
    } t_flags;

endpackage

// ----- rtl/core/tcc_seq.sv -----
// ----------------------------------------------------------------------------
// tcc_seq
// Micro-sequencer: control-store ROM, micro-PC, mode dispatch and branches.
// ----------------------------------------------------------------------------
module tcc_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  logic [1:0]      i_mode,
    input  tcc_pkg::t_flags i_flags,
    input  logic            i_out_busy,
    output tcc_pkg::t_ctl   o_ctl,
    output logic            o_idle,
    output logic            o_emit
);
    import tcc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_seq_state;

    function automatic t_uword ucode(input logic [UW-1:0] pc);
        t_uword w;
        w = '{addr_op: A_HOLD, we: WE_OFF, wsel: W_BLANK, asel: WA_CNT, rd_en: 1'b0,
              rsel: R_CELL, cur_op: CUR_NONE, cond: C_NEVER, target: S_INIT, fin: E_NONE};
        case (pc)
            S_INIT: begin
                w.addr_op = A_ZERO;
            end
            S_INIT_FILL: begin
                w.we = WE_ON; w.wsel = W_RESET; w.addr_op = A_INC;
                w.cond = C_FILL_MORE; w.target = S_INIT_FILL; w.fin = E_QUIET;
            end
            S_CLR: begin
                w.addr_op = A_ZERO; w.cur_op = CUR_HOME;
            end
            S_CLR_FILL: begin
                w.we = WE_ON; w.wsel = W_BLANK; w.addr_op = A_INC;
                w.cond = C_FILL_MORE; w.target = S_CLR_FILL; w.fin = E_RESULT;
            end
            S_READ: begin
                w.rd_en = 1'b1; w.rsel = R_CELL;
            end
            S_RESULT: begin
                w.fin = E_RESULT;
            end
            S_PUT: begin
                w.we = WE_PRINT; w.wsel = W_CHAR; w.asel = WA_CUR; w.addr_op = A_ZERO;
                w.cur_op = CUR_PUT; w.cond = C_SCROLL; w.target = S_COPY_RD;
                w.fin = E_RESULT;
            end
            S_COPY_RD: begin
                w.rd_en = 1'b1; w.rsel = R_NEXT;
            end
            S_COPY_WR: begin
                w.we = WE_ON; w.wsel = W_COPY; w.addr_op = A_INC;
                w.cond = C_COPY_MORE; w.target = S_COPY_RD;
            end
            S_FILL_LAST: begin
                w.we = WE_ON; w.wsel = W_BLANK; w.addr_op = A_INC;
                w.cond = C_FILL_MORE; w.target = S_FILL_LAST; w.fin = E_RESULT;
            end
            default: begin
                w.fin = E_QUIET;
            end
        endcase
        return w;
    endfunction

    t_seq_state    r_state, n_state;
    logic [UW-1:0] r_upc, n_upc;
    t_uword        uw;
    logic          run, hit, finish, stall, en;

    assign uw  = ucode(r_upc);
    assign run = (r_state == ST_RUN);

    always_comb begin
        case (uw.cond)
            C_SCROLL:    hit = i_flags.need_scroll;
            C_COPY_MORE: hit = !i_flags.copy_end;
            C_FILL_MORE: hit = !i_flags.fill_end;
            default:     hit = 1'b0;
        endcase
    end

    assign finish = run && !hit && (uw.fin != E_NONE);
    // result cannot leave while the output register is still full
    assign stall  = finish && (uw.fin == E_RESULT) && i_out_busy;
    assign en     = run && !stall;

    always_comb begin
        n_state = r_state;
        n_upc   = r_upc;
        if (i_take) begin
            n_state = ST_RUN;
            case (i_mode)
                MODE_PUT:   n_upc = S_PUT;
                MODE_READ:  n_upc = S_READ;
                MODE_CLEAR: n_upc = S_CLR;
                default:    n_upc = S_RESULT;
            endcase
        end else if (en) begin
            if (hit) begin
                n_upc = uw.target;
            end else if (finish) begin
                n_state = ST_IDLE;
            end else begin
                n_upc = r_upc + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_upc   <= S_INIT;
        end else begin
            r_state <= n_state;
            r_upc   <= n_upc;
        end
    end

    assign o_ctl  = '{uw: uw, en: en, take: i_take};
    assign o_idle = (r_state == ST_IDLE);
    assign o_emit = en && finish && (uw.fin == E_RESULT);

endmodule

// ----- rtl/core/tcc_dp.sv -----
// ----------------------------------------------------------------------------
// tcc_dp
// Datapath: screen store, address counter, cursor, attribute and word fields.
// ----------------------------------------------------------------------------
module tcc_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tcc_pkg::t_ctl        i_ctl,
    input  logic [1:0]           i_mode,
    input  logic [7:0]           i_char_code,
    input  logic [tcc_pkg::RW-1:0] i_read_row,
    input  logic [tcc_pkg::CW-1:0] i_read_col,
    input  logic                 i_cfg_wen,
    input  logic [7:0]           i_cfg_wdata,
    output tcc_pkg::t_flags      o_flags,
    output logic [tcc_pkg::RW-1:0] o_cursor_row,
    output logic [tcc_pkg::CW-1:0] o_cursor_col,
    output logic [15:0]          o_cell_data,
    output logic                 o_scrolled
);
    import tcc_pkg::*;

    logic [15:0]   mem [CELLS];
    logic [15:0]   r_rdata;

    logic [AW-1:0] r_addr;
    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic [7:0]    r_attr;
    logic          r_scr, n_scr;
    logic [1:0]    r_mode;
    logic [7:0]    r_char;
    logic [RW-1:0] r_rr;
    logic [CW-1:0] r_rc;

    logic [AW-1:0] cur_addr, rd_addr, waddr, raddr;
    logic [15:0]   wdata;
    logic          is_print, we_act, rd_act, in_range;
    logic [CW:0]   pc;
    logic [RW:0]   pr;
    logic          need_scroll;

    assign cur_addr = AW'(AW'(r_row) * AW'(COLUMNS)) + AW'(r_col);
    assign rd_addr  = AW'(AW'(r_rr) * AW'(COLUMNS)) + AW'(r_rc);
    assign in_range = (RW'(r_rr) < RW'(ROWS)) && ({1'b0, r_rc} < (CW+1)'(COLUMNS));

    assign is_print = (r_char != CH_LF) && (r_char != CH_CR) &&
                      (r_char != CH_BS) && (r_char != CH_TAB);

    // cursor advance for a put, with line wrap and the scroll test
    always_comb begin
        pr = {1'b0, r_row};
        case (r_char)
            CH_LF: begin
                pc = '0;
                pr = {1'b0, r_row} + 1'b1;
            end
            CH_CR:   pc = '0;
            CH_BS:   pc = (r_col == '0) ? '0 : {1'b0, r_col} - 1'b1;
            CH_TAB:  pc = ({1'b0, r_col} + (CW+1)'(4)) & ~(CW+1)'(3);
            default: pc = {1'b0, r_col} + 1'b1;
        endcase
        if (pc >= (CW+1)'(COLUMNS)) begin
            pc = '0;
            pr = pr + 1'b1;
        end
        need_scroll = (pr >= (RW+1)'(ROWS));
    end

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        n_scr = r_scr;
        case (i_ctl.uw.cur_op)
            CUR_PUT: begin
                n_row = need_scroll ? RW'(ROWS - 1) : pr[RW-1:0];
                n_col = pc[CW-1:0];
                n_scr = need_scroll;
            end
            CUR_HOME: begin
                n_row = '0;
                n_col = '0;
            end
            default: begin
                n_row = r_row;
            end
        endcase
    end

    always_comb begin
        case (i_ctl.uw.wsel)
            W_RESET: wdata = CELL_RESET;
            W_CHAR:  wdata = {r_attr, r_char};
            W_COPY:  wdata = r_rdata;
            default: wdata = {r_attr, CH_SPACE};
        endcase
    end

    assign we_act = i_ctl.en && ((i_ctl.uw.we == WE_ON) ||
                                 ((i_ctl.uw.we == WE_PRINT) && is_print));
    assign rd_act = i_ctl.en && i_ctl.uw.rd_en;
    assign waddr  = (i_ctl.uw.asel == WA_CUR) ? cur_addr : r_addr;
    assign raddr  = (i_ctl.uw.rsel == R_CELL) ? rd_addr : r_addr + AW'(COLUMNS);

    always_ff @(posedge i_clk) begin
        if (we_act) begin
            mem[waddr] <= wdata;
        end
        if (rd_act) begin
            r_rdata <= mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            case (i_ctl.uw.addr_op)
                A_ZERO:  r_addr <= '0;
                A_INC:   r_addr <= r_addr + 1'b1;
                default: r_addr <= r_addr;
            endcase
        end
        if (i_ctl.take) begin
            r_mode <= i_mode;
            r_char <= i_char_code;
            r_rr   <= i_read_row;
            r_rc   <= i_read_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_scr  <= 1'b0;
            r_attr <= ATTR_RESET;
        end else begin
            if (i_ctl.take) begin
                r_scr <= 1'b0;
            end else if (i_ctl.en) begin
                r_row <= n_row;
                r_col <= n_col;
                r_scr <= n_scr;
            end
            if (i_cfg_wen) begin
                r_attr <= i_cfg_wdata;
            end
        end
    end

    assign o_flags = '{need_scroll: need_scroll,
                       copy_end:    (r_addr == ADDR_COPY_LAST),
                       fill_end:    (r_addr == ADDR_LAST)};

    assign o_cursor_row = n_row;
    assign o_cursor_col = n_col;
    assign o_cell_data  = ((r_mode == MODE_READ) && in_range) ? r_rdata : 16'h0000;
    assign o_scrolled   = n_scr;

endmodule

// ----- rtl/core/text_console_cursor_engine.sv -----
// Throughput: one word at a time; micro-steps read and write the screen store separately,
//   one cell per cycle for a fill and a read then a write per cell for the row copy.
// Reset: synchronous, active low; a clearing pass over every cell follows,
//   with o_s_tready low until it ends. Attribute register writes are taken throughout.
// ----------------------------------------------------------------------------
// text_console_cursor_engine
// Text-mode console with cursor: microcoded control over a screen store.
// ----------------------------------------------------------------------------
module text_console_cursor_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // char_code[7:0], read_row[12:8], read_col[19:13]
    input  logic [1:0]  i_s_tuser,   // mode[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // cursor_row[4:0], cursor_col[11:5],
                                     // cell_data[27:12], scrolled[28]
    input  logic        i_cfg_wen,
    input  logic [7:0]  i_cfg_wdata
);
    import tcc_pkg::*;

    t_ctl          ctl;
    t_flags        flags;
    logic          idle, emit, take, out_busy;
    logic [RW-1:0] cur_row;
    logic [CW-1:0] cur_col;
    logic [15:0]   cell_data;
    logic          scr;

    logic          r_m_valid;
    logic [31:0]   r_m_data;

    assign o_s_tready = idle;
    assign take       = i_s_tvalid && idle;
    assign out_busy   = r_m_valid && !i_m_tready;

    tcc_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_mode     (i_s_tuser),
        .i_flags    (flags),
        .i_out_busy (out_busy),
        .o_ctl      (ctl),
        .o_idle     (idle),
        .o_emit     (emit)
    );

    tcc_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .i_mode       (i_s_tuser),
        .i_char_code  (i_s_tdata[7:0]),
        .i_read_row   (i_s_tdata[12:8]),
        .i_read_col   (i_s_tdata[19:13]),
        .i_cfg_wen    (i_cfg_wen),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_flags      (flags),
        .o_cursor_row (cur_row),
        .o_cursor_col (cur_col),
        .o_cell_data  (cell_data),
        .o_scrolled   (scr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (emit) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_m_data <= {3'b000, scr, cell_data, cur_col, cur_row};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

endmodule

// ----- bench/text_console_cursor_engine_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_cursor_engine_checker
// Watches the input, result and attribute ports, keeps a shadow screen and
// cursor, predicts one result word per accepted input word and compares
// each result word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [23:0] i_s_tdata,   // char_code[7:0], read_row[12:8], read_col[19:13]
    input  logic [1:0]  i_s_tuser,   // mode[1:0]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,   // cursor_row[4:0], cursor_col[11:5],
                                     // cell_data[27:12], scrolled[28]
    input  logic        i_cfg_wen,
    input  logic [7:0]  i_cfg_wdata,
    output int          o_pending,
    output int          o_fail_count
);
    import tcc_pkg::*;

    // same bit order as the result word, cursor row lowest
    typedef struct packed {
        logic          scrolled;
        logic [15:0]   cell_data;
        logic [CW-1:0] col;
        logic [RW-1:0] row;
    } t_console_result;

    logic [15:0]     shadow_screen [CELLS];
    logic [RW-1:0]   shadow_row;
    logic [CW-1:0]   shadow_col;
    logic [7:0]      shadow_attr;
    t_console_result results_due[$];
    int              fail_count = 0;
    int              due_count  = 0;

    assign o_pending    = due_count;
    assign o_fail_count = fail_count;

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    // One console step on the shadow state; returns the result word it causes.
    task automatic advance_console(input logic [1:0] mode, input logic [7:0] ch,
                                   input logic [4:0] rd_row, input logic [6:0] rd_col,
                                   output t_console_result res);
        int          row;
        int          col;
        int          i;
        logic [15:0] blank;
        row   = int'(shadow_row);
        col   = int'(shadow_col);
        blank = {shadow_attr, CH_SPACE};
        res   = '0;
        case (mode)
            MODE_PUT: begin
                if (ch == CH_LF) begin
                    col = 0;
                    row++;
                end else if (ch == CH_CR) begin
                    col = 0;
                end else if (ch == CH_BS) begin
                    if (col > 0)
                        col--;
                end else if (ch == CH_TAB) begin
                    col = (col + 4) & ~3;
                end else begin
                    shadow_screen[row * COLUMNS + col] = {shadow_attr, ch};
                    col++;
                end
                if (col >= COLUMNS) begin
                    col = 0;
                    row++;
                end
                if (row >= ROWS) begin
                    for (i = 0; i < (ROWS - 1) * COLUMNS; i++)
                        shadow_screen[i] = shadow_screen[i + COLUMNS];
                    for (i = (ROWS - 1) * COLUMNS; i < CELLS; i++)
                        shadow_screen[i] = blank;
                    row          = ROWS - 1;
                    res.scrolled = 1'b1;
                end
            end
            MODE_READ: begin
                if (rd_row < ROWS && rd_col < COLUMNS)
                    res.cell_data = shadow_screen[rd_row * COLUMNS + rd_col];
            end
            MODE_CLEAR: begin
                for (i = 0; i < CELLS; i++)
                    shadow_screen[i] = blank;
                row = 0;
                col = 0;
            end
            default: ;   // spare mode leaves everything alone
        endcase
        shadow_row = row[RW-1:0];
        shadow_col = col[CW-1:0];
        res.row    = shadow_row;
        res.col    = shadow_col;
    endtask

    always @(posedge i_clk) begin : watch
        t_console_result got;
        t_console_result want;
        int              i;
        if (!i_rst_n) begin
            for (i = 0; i < CELLS; i++)
                shadow_screen[i] = CELL_RESET;
            shadow_row  = '0;
            shadow_col  = '0;
            shadow_attr = ATTR_RESET;
        end else begin
            if (i_cfg_wen)
                shadow_attr = i_cfg_wdata;
            // results belong to earlier words, so retire before predicting
            if (i_m_tvalid && i_m_tready) begin
                got = t_console_result'(i_m_tdata[28:0]);
                if (results_due.size() == 0) begin
                    $error("result word with nothing expected: 0x%0h", i_m_tdata);
                    fail_count++;
                end else begin
                    want = results_due.pop_front();
                    check_field("cursor_row", int'(want.row), int'(got.row));
                    check_field("cursor_col", int'(want.col), int'(got.col));
                    check_field("cell_data", int'(want.cell_data), int'(got.cell_data));
                    check_field("scrolled", int'(want.scrolled), int'(got.scrolled));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                advance_console(i_s_tuser, i_s_tdata[7:0], i_s_tdata[12:8],
                                i_s_tdata[19:13], want);
                results_due.push_back(want);
            end
        end
        due_count = results_due.size();
    end

endmodule

// ----- bench/text_console_cursor_engine_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_cursor_engine_tb
// Drives console words into the engine: a short directed opening, then
// phases of random text, reads and clears, each under its own attribute,
// with bursty input and a stalling receiver. The checker does the scoring.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_tb;
    import tcc_pkg::*;

    localparam logic [1:0] MODE_SPARE      = 2'd3;
    localparam int         PHASES          = 5;
    localparam int         WORDS_PER_PHASE = 285;

    typedef enum int {RX_OPEN, RX_COIN, RX_HICCUP} t_rx_style;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_wen   = 1'b0;
    logic [7:0]  cfg_wdata = '0;
    int          pending;
    int          fail_count;
    int          lf_pct    = 0;

    t_rx_style   rx_style  = RX_OPEN;
    int          rx_stall  = 0;
    int          rx_cycle  = 0;

    text_console_cursor_engine dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_wen   (cfg_wen),
        .i_cfg_wdata (cfg_wdata)
    );

    text_console_cursor_engine_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_cfg_wen    (cfg_wen),
        .i_cfg_wdata  (cfg_wdata),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver: redraws its ready style at random, open, coin toss or hiccup
    always @(negedge clk) begin : receiver
        logic ready;
        if (rx_cycle % 300 == 0)
            rx_style = t_rx_style'($urandom_range(2));
        rx_cycle++;
        if (rx_stall > 0) begin
            rx_stall--;
            ready = 1'b0;
        end else begin
            case (rx_style)
                RX_OPEN: ready = 1'b1;
                RX_COIN: ready = 1'($urandom_range(1));
                default: begin
                    if ($urandom_range(15) == 0) begin
                        rx_stall = $urandom_range(23, 1);
                        ready    = 1'b0;
                    end else begin
                        ready = 1'b1;
                    end
                end
            endcase
        end
        m_tready <= ready;
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    // with tvalid still high, so the next word can follow without a gap.
    task automatic send_word(input logic [1:0] mode, input logic [7:0] ch,
                             input logic [4:0] row, input logic [6:0] col);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {4'b0000, col, row, ch};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_attr(input logic [7:0] value);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_wen   <= 1'b0;
    endtask

    function automatic logic [7:0] next_char();
        int r;
        r = $urandom_range(99);
        if (r < lf_pct)
            return CH_LF;
        if (r < lf_pct + 5)
            return CH_TAB;
        if (r < lf_pct + 8)
            return CH_BS;
        if (r < lf_pct + 10)
            return CH_CR;
        return 8'($urandom_range(126, 32));
    endfunction

    task automatic send_random_word();
        int         pick;
        logic [7:0] ch;
        logic [4:0] row;
        logic [6:0] col;
        pick = $urandom_range(999);
        ch   = 8'($urandom_range(255));
        row  = 5'($urandom_range(31));
        col  = 7'($urandom_range(127));
        if (pick < 800) begin
            send_word(MODE_PUT, next_char(), row, col);
        end else if (pick < 950) begin
            // mostly in-range reads; the rest use any row and column, some out of range
            if ($urandom_range(9) != 0) begin
                row = 5'($urandom_range(ROWS - 1));
                col = 7'($urandom_range(COLUMNS - 1));
            end
            send_word(MODE_READ, ch, row, col);
        end else if (pick < 975) begin
            send_word(MODE_SPARE, ch, row, col);
        end else if (pick < 978) begin
            send_word(MODE_CLEAR, ch, row, col);
        end else begin
            send_word(MODE_PUT, ch, row, col);
        end
    endtask

    // Bursts pick at random between short lines and long runs that wrap,
    // so tabs land near the right edge and the bottom row scrolls often.
    task automatic run_phase(input int words);
        int burst;
        int gap;
        burst = 0;
        for (int n = 0; n < words; n++) begin
            if (burst == 0) begin
                burst  = $urandom_range(40, 1);
                lf_pct = $urandom_range(1) ? 10 : 0;
                gap    = ($urandom_range(2) == 0) ? 0 : $urandom_range(12, 1);
                if (gap > 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            send_random_word();
            burst--;
        end
    endtask

    initial begin
        logic [7:0] attr;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // reset contents, out-of-range reads, spare mode, control characters
        send_word(MODE_READ, 8'h00, 5'd0, 7'd0);
        send_word(MODE_READ, 8'hFF, 5'd24, 7'd79);
        send_word(MODE_READ, 8'h00, 5'd31, 7'd0);
        send_word(MODE_READ, 8'h00, 5'd0, 7'd127);
        send_word(MODE_READ, 8'h00, 5'd25, 7'd80);
        send_word(MODE_SPARE, 8'hFF, 5'd31, 7'd127);
        send_word(MODE_PUT, 8'h41, 5'd0, 7'd0);
        send_word(MODE_PUT, 8'h00, 5'd31, 7'd127);
        send_word(MODE_PUT, 8'hFF, 5'd0, 7'd0);
        send_word(MODE_PUT, CH_BS, 5'd0, 7'd0);
        send_word(MODE_PUT, CH_TAB, 5'd0, 7'd0);
        send_word(MODE_PUT, CH_CR, 5'd0, 7'd0);
        send_word(MODE_PUT, CH_BS, 5'd0, 7'd0);
        send_word(MODE_PUT, CH_LF, 5'd0, 7'd0);
        send_word(MODE_PUT, CH_TAB, 5'd0, 7'd0);
        send_word(MODE_PUT, 8'hA5, 5'd0, 7'd0);
        send_word(MODE_READ, 8'h00, 5'd0, 7'd0);
        send_word(MODE_READ, 8'h00, 5'd0, 7'd1);
        send_word(MODE_READ, 8'h00, 5'd0, 7'd2);
        send_word(MODE_READ, 8'h00, 5'd1, 7'd4);
        send_word(MODE_CLEAR, 8'h00, 5'd0, 7'd0);
        send_word(MODE_READ, 8'h00, 5'd0, 7'd0);
        send_word(MODE_READ, 8'h00, 5'd24, 7'd79);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       attr = 8'hFF;
                1:       attr = 8'h00;
                3:       attr = 8'hA5;
                default: attr = 8'($urandom_range(255));
            endcase
            write_attr(attr);
            if (p == 1)
                send_word(MODE_CLEAR, 8'hFF, 5'd31, 7'd127);
            run_phase(WORDS_PER_PHASE);
            drain();
        end

        // longest step is a scrolling put
        repeat (4000) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("** text_console_cursor_engine: PASSED **");
        else
            $display("** text_console_cursor_engine: FAILED **");
        $finish;
    end

    initial begin
        #(64'd200_000_000);
        $display("** text_console_cursor_engine: FAILED **");
        $finish;
    end

endmodule
